>>> hdl/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

  // Operation codes; code 15 has no meaning and yields an all-zero result
  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_GT    = 4'd4,
    CMD_LT    = 4'd5,
    CMD_GE    = 4'd6,
    CMD_LE    = 4'd7,
    CMD_EQ    = 4'd8,
    CMD_NE    = 4'd9,
    CMD_MIN   = 4'd10,
    CMD_MAX   = 4'd11,
    CMD_INC   = 4'd12,
    CMD_DEC   = 4'd13,
    CMD_TOINT = 4'd14
  } cmd_t;

  localparam int unsigned DataWidth = 32;

  // Item as it travels down the divider chain
  typedef struct packed {
    cmd_t                   cmd;
    logic [DataWidth-1:0]   res;   // finished result of every non-divide command
    logic                   cmp;
    logic                   dz;
    logic                   neg;   // quotient sign
    logic [DataWidth-1:0]   dvs;   // divisor magnitude
    logic [DataWidth-1:0]   num;   // dividend bits still to bring down, MSB first
    logic [DataWidth-1:0]   rem;   // partial remainder
    logic [DataWidth-1:0]   quo;   // low quotient bits so far
  } item_t;

endpackage

>>> hdl/fpa_in_if.sv
`timescale 1ns / 1ps

interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

>>> hdl/fpa_out_if.sv
`timescale 1ns / 1ps

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;

  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

>>> hdl/fpa_front.sv
`timescale 1ns / 1ps

module fpa_front
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  fpa_in_if.sink     request,
  output logic       down_valid,
  output item_t      down_item,
  input  logic       down_ready
);

  logic               valid;
  item_t              item;
  logic signed [63:0] prod;

  logic signed [31:0] a;
  logic signed [31:0] b;
  cmd_t               cmd;
  item_t              item_next;
  logic signed [63:0] prod_next;
  logic               a_lt_b;
  logic               a_gt_b;
  logic               a_eq_b;

  assign a   = request.operand_a;
  assign b   = request.operand_b;
  assign cmd = cmd_t'(request.command);

  assign a_lt_b = a < b;
  assign a_gt_b = a > b;
  assign a_eq_b = a == b;

  assign prod_next = 64'(a) * 64'(b);

  // Evaluate every command but multiply and divide, and seed the divider
  always_comb begin
    item_next     = '0;
    item_next.cmd = cmd;
    item_next.neg = a[31] ^ b[31];
    item_next.dvs = b[31] ? (~b + 32'd1) : b;
    item_next.num = a[31] ? (~a + 32'd1) : a;
    item_next.dz  = (cmd == CMD_DIV) && (b == 32'sd0);
    case (cmd)
      CMD_ADD:   item_next.res = a + b;
      CMD_SUB:   item_next.res = a - b;
      CMD_GT:    item_next.cmp = a_gt_b;
      CMD_LT:    item_next.cmp = a_lt_b;
      CMD_GE:    item_next.cmp = !a_lt_b;
      CMD_LE:    item_next.cmp = !a_gt_b;
      CMD_EQ:    item_next.cmp = a_eq_b;
      CMD_NE:    item_next.cmp = !a_eq_b;
      CMD_MIN:   item_next.res = a_lt_b ? a : b;
      CMD_MAX:   item_next.res = a_gt_b ? a : b;
      CMD_INC:   item_next.res = a + 32'sd1;
      CMD_DEC:   item_next.res = a - 32'sd1;
      CMD_TOINT: item_next.res = a >>> FRAC_BITS;
      default:   item_next.res = '0;
    endcase
  end

  assign request.ready = !valid || down_ready;

  // Hold the item until the first cell takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (request.ready) begin
      valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      item <= item_next;
      prod <= prod_next;
    end
  end

  // Scale the registered product back to the fixed-point grid
  always_comb begin
    down_item = item;
    if (item.cmd == CMD_MUL) begin
      down_item.res = prod[FRAC_BITS +: DataWidth];
    end
  end

  assign down_valid = valid;

endmodule

>>> hdl/fpa_div_cell.sv
`timescale 1ns / 1ps

module fpa_div_cell
  import fpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  input  item_t up_item,
  output logic  up_ready,
  output logic  down_valid,
  output item_t down_item,
  input  logic  down_ready
);

  logic  valid;
  item_t item;

  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;
  logic               fits;
  item_t              item_next;

  // One restoring step: bring down a bit, subtract if the divisor fits
  assign trial = {up_item.rem, up_item.num[DataWidth-1]};
  assign diff  = trial - {1'b0, up_item.dvs};
  assign fits  = trial >= {1'b0, up_item.dvs};

  always_comb begin
    item_next     = up_item;
    item_next.rem = fits ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    item_next.num = {up_item.num[DataWidth-2:0], 1'b0};
    item_next.quo = {up_item.quo[DataWidth-2:0], fits};
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign down_valid = valid;
  assign down_item  = item;

endmodule

>>> hdl/fpa_back.sv
`timescale 1ns / 1ps

module fpa_back
  import fpa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  input  item_t  up_item,
  output logic   up_ready,
  fpa_out_if.source response
);

  logic                 valid;
  logic [DataWidth-1:0] res;
  logic                 cmp;
  logic                 dz;

  logic [DataWidth-1:0] res_next;

  // Apply the quotient sign; a zero divisor forces a zero result
  always_comb begin
    res_next = up_item.res;
    if (up_item.cmd == CMD_DIV) begin
      if (up_item.dz) begin
        res_next = '0;
      end else if (up_item.neg) begin
        res_next = ~up_item.quo + 32'd1;
      end else begin
        res_next = up_item.quo;
      end
    end
  end

  assign up_ready = !valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res <= res_next;
      cmp <= up_item.cmp;
      dz  <= up_item.dz;
    end
  end

  assign response.valid          = valid;
  assign response.result_value   = res;
  assign response.compare_true   = cmp;
  assign response.divide_by_zero = dz;

endmodule

>>> hdl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is ready; every stage holds its own
// valid bit, so gaps close up while the output waits. The depth is set by the divider,
// one quotient bit per cell.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.

module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  fpa_in_if.sink     request,
  fpa_out_if.source  response
);

  localparam int Stages = DataWidth + FRAC_BITS;

  logic  chain_valid [0:Stages];
  logic  chain_ready [0:Stages];
  item_t chain_item  [0:Stages];

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .down_valid (chain_valid[0]),
    .down_item  (chain_item[0]),
    .down_ready (chain_ready[0])
  );

  // Divider chain: each cell produces one quotient bit
  for (genvar i = 0; i < Stages; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[i]),
      .up_item    (chain_item[i]),
      .up_ready   (chain_ready[i]),
      .down_valid (chain_valid[i+1]),
      .down_item  (chain_item[i+1]),
      .down_ready (chain_ready[i+1])
    );
  end

  fpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[Stages]),
    .up_item  (chain_item[Stages]),
    .up_ready (chain_ready[Stages]),
    .response (response)
  );

endmodule

>>> tb/sv/fixed_point_alu_test.sv
`timescale 1ns / 1ps

module fixed_point_alu_test;
  import fpa_pkg::*;

  localparam int FRAC_BITS      = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_OPS     = 600;
  localparam int TAIL_OPS       = 60;
  localparam int PRESSURE_AT    = 180;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = FRAC_BITS + 34 + 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 60;

  // Code 15 carries no operation; the block must answer with all zeros
  localparam logic [3:0] CMD_UNUSED = 4'hF;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_res_t;

  typedef struct packed {
    alu_op_t  op;
    alu_res_t res;
  } alu_expect_t;

  logic clk;
  logic rst;

  fpa_in_if  req_if ();
  fpa_out_if rsp_if ();

  fixed_point_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .response(rsp_if)
  );

  alu_op_t     ops_to_send[$];
  alu_expect_t results_due[$];
  alu_op_t     op_on_bus;
  alu_expect_t got_expect;
  int          total_ops;
  int          accepted_ops;
  int          fail_count;
  int          src_gap;
  int          snk_gap;
  int          hold_left;
  bit          pressure_done;
  int          stall_cycles;

  // Compute the result of one ALU operation
  function automatic alu_res_t alu_result(alu_op_t op);
    alu_res_t           r;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] prod;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic [63:0]        quo;
    r  = '0;
    sa = op.a;
    sb = op.b;
    wa = {{32{op.a[31]}}, op.a};
    wb = {{32{op.b[31]}}, op.b};
    case (op.command)
      CMD_ADD: r.value = op.a + op.b;
      CMD_SUB: r.value = op.a - op.b;
      CMD_MUL: begin
        prod    = wa * wb;
        r.value = prod[FRAC_BITS +: 32];
      end
      CMD_DIV: begin
        if (op.b == 32'd0) begin
          r.dz = 1'b1;
        end else begin
          mag_a = wa[63] ? -wa : wa;
          mag_b = wb[63] ? -wb : wb;
          quo   = (mag_a << FRAC_BITS) / mag_b;
          if (op.a[31] != op.b[31]) quo = -quo;
          r.value = quo[31:0];
        end
      end
      CMD_GT:    r.cmp = sa > sb;
      CMD_LT:    r.cmp = sa < sb;
      CMD_GE:    r.cmp = sa >= sb;
      CMD_LE:    r.cmp = sa <= sb;
      CMD_EQ:    r.cmp = sa == sb;
      CMD_NE:    r.cmp = sa != sb;
      CMD_MIN:   r.value = (sa < sb) ? op.a : op.b;
      CMD_MAX:   r.value = (sa > sb) ? op.a : op.b;
      CMD_INC:   r.value = op.a + 32'd1;
      CMD_DEC:   r.value = op.a - 32'd1;
      CMD_TOINT: r.value = wa[FRAC_BITS +: 32];
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic void queue_op(logic [3:0] command, logic [31:0] a, logic [31:0] b);
    alu_op_t op;
    op.command = command;
    op.a       = a;
    op.b       = b;
    ops_to_send.push_back(op);
  endfunction

  // Mix extremes, small signed values, whole numbers and raw random bits
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    return 32'($urandom_range(0, 4095)) - 32'd2048;
      3:       return (32'($urandom_range(0, 511)) - 32'd256) << FRAC_BITS;
      default: return $urandom();
    endcase
  endfunction

  // Idle only outside the tail, and leave quiet stretches between bursts
  function automatic bit idle_allowed();
    return ops_to_send.size() > TAIL_OPS && (accepted_ops % 96) < 64;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive the request side from the pending queue; log expectations on accept
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        results_due.push_back({op_on_bus, alu_result(op_on_bus)});
        accepted_ops++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (ops_to_send.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 8);
          req_if.valid <= 1'b0;
        end else begin
          op_on_bus = ops_to_send.pop_front();
          req_if.command   <= op_on_bus.command;
          req_if.operand_a <= op_on_bus.a;
          req_if.operand_b <= op_on_bus.b;
          req_if.valid     <= 1'b1;
        end
      end
    end
  end

  // Check each result against the oldest expectation and pace ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no operation pending");
        end else begin
          got_expect = results_due.pop_front();
          if (rsp_if.result_value !== got_expect.res.value)
            report_mismatch($sformatf("cmd %0d a %h b %h: value %h, want %h",
                got_expect.op.command, got_expect.op.a, got_expect.op.b,
                rsp_if.result_value, got_expect.res.value));
          if (rsp_if.compare_true !== got_expect.res.cmp)
            report_mismatch($sformatf("cmd %0d a %h b %h: compare_true %b, want %b",
                got_expect.op.command, got_expect.op.a, got_expect.op.b,
                rsp_if.compare_true, got_expect.res.cmp));
          if (rsp_if.divide_by_zero !== got_expect.res.dz)
            report_mismatch($sformatf("cmd %0d a %h b %h: divide_by_zero %b, want %b",
                got_expect.op.command, got_expect.op.a, got_expect.op.b,
                rsp_if.divide_by_zero, got_expect.res.dz));
        end
      end
      // Hold off once for a long stretch so the pipeline fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!pressure_done && accepted_ops >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rsp_if.ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 8);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Build the stimulus, run reset, wait for the drain and give the verdict
  initial begin
    logic [3:0]  command;
    logic [31:0] a;
    logic [31:0] b;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.command   = 4'd0;
    req_if.operand_a = 32'd0;
    req_if.operand_b = 32'd0;
    rsp_if.ready     = 1'b0;
    accepted_ops     = 0;
    fail_count       = 0;
    pressure_done    = 1'b0;
    stall_cycles     = 0;

    // Wrap on add and subtract
    queue_op(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_op(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    queue_op(CMD_SUB, 32'h0000_0000, 32'h7FFF_FFFF);
    // Product overflow, sign handling and rounding of tiny negatives
    queue_op(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_MUL, 32'hFFFF_FF00, 32'h0000_0180);
    queue_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    // Divide by zero, quotient overflow and truncation toward zero
    queue_op(CMD_DIV, 32'h0000_0300, 32'h0000_0000);
    queue_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(CMD_DIV, 32'hFFFF_FD00, 32'h0000_0200);
    queue_op(CMD_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
    // Compares at the extremes and with equal operands
    queue_op(CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(CMD_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_op(CMD_GE, 32'h1234_5678, 32'h1234_5678);
    queue_op(CMD_LE, 32'h0000_0001, 32'h0000_0000);
    queue_op(CMD_EQ, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Min and max, equal operands among them
    queue_op(CMD_MIN, 32'hFFFF_0000, 32'hFFFF_0000);
    queue_op(CMD_MIN, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_op(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    // Step by one LSB across the wrap points, integer part of both signs
    queue_op(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_op(CMD_DEC, 32'h8000_0000, 32'h0000_0000);
    queue_op(CMD_TOINT, 32'hFFFF_FE80, 32'h5555_5555);
    queue_op(CMD_TOINT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    queue_op(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random operations, with equal operands and zero divisors mixed in
    repeat (RANDOM_OPS) begin
      command = ($urandom_range(0, 63) == 0) ? CMD_UNUSED : 4'($urandom_range(0, 14));
      a = pick_operand();
      b = ($urandom_range(0, 5) == 0) ? a : pick_operand();
      if (command == CMD_DIV && $urandom_range(0, 7) == 0) b = 32'd0;
      queue_op(command, a, b);
    end
    total_ops = ops_to_send.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_ops == total_ops && results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
